// ===== rtl/aes_pkg.sv =====
// Package for the AES block encryptor: payload structs, state codes and the
// S-box, xtime and round-constant functions. No dependencies.
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } aes_out_t;

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tab [256];
        tab = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tab[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] n);
        logic [7:0] r;
        case (n)
            4'd0: r = 8'h01;
            4'd1: r = 8'h02;
            4'd2: r = 8'h04;
            4'd3: r = 8'h08;
            4'd4: r = 8'h10;
            4'd5: r = 8'h20;
            4'd6: r = 8'h40;
            4'd7: r = 8'h80;
            4'd8: r = 8'h1b;
            4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/aes_round.sv =====
// Shared AES round datapath: SubBytes, ShiftRows, optional MixColumns and
// AddRoundKey on one 128-bit state. Depends on aes_pkg.
module aes_round
    import aes_pkg::*;
(
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         do_mix,
    output logic [127:0] state_out
);

    logic [7:0] s  [16];
    logic [7:0] t  [16];
    logic [7:0] m  [16];
    logic [127:0] mixed;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (do_mix) begin
                m[4*c+0] = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
                m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
            end else begin
                for (int r = 0; r < 4; r++) begin
                    m[4*c + r] = t[4*c + r];
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            mixed[127 - 8*i -: 8] = m[i];
        end
        state_out = mixed ^ round_key;
    end

endmodule

// ===== rtl/aes_block_encryptor.sv =====
// AES block encryptor (FIPS-197, 128/192/256-bit keys), top level.
// One block is in flight at a time: the single shared round unit applies the
// Nr rounds (10, 12 or 14) of an accepted block, and a new block is taken only
// after m_valid has been answered by m_ready.
// Reset (aresetn, synchronous, active low) clears the key registers and then
// runs a key expansion of 4*(Nr+1) words (44 after reset) before s_ready rises.
module aes_block_encryptor
    import aes_pkg::*;
#(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  aes_in_t       s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output aes_out_t      m_data
);

    localparam int WW = $clog2(ROUND_KEY_WORDS + 1);

    // Configuration registers.
    logic [1:0]  key_size_reg;
    logic [63:0] key_word_reg [4];

    // Effective key size: size three acts as 256 bits, and a schedule that
    // exceeds ROUND_KEY_WORDS words is lowered to the largest that fits, or to 128.
    logic [1:0] ks_eff;
    logic [3:0] nk;
    logic [3:0] num_rounds;
    logic [WW-1:0] total_words;

    always_comb begin
        ks_eff = (key_size_reg == 2'd3) ? KEY_256 : key_size_reg;
        if (ks_eff == KEY_256 && ROUND_KEY_WORDS < 60) begin
            ks_eff = KEY_192;
        end
        if (ks_eff == KEY_192 && ROUND_KEY_WORDS < 52) begin
            ks_eff = KEY_128;
        end
        nk          = 4'd4 + {1'b0, ks_eff, 1'b0};
        num_rounds  = nk + 4'd6;
        total_words = WW'({num_rounds + 4'd1, 2'b00});
    end

    // Key expansion produces one word per cycle. Words below nk come from the key
    // registers; word i >= nk comes from word i-1 (hist_reg[0]) and word i-nk,
    // both taken from a shift line of the last eight words.
    logic [31:0] hist_reg [8];
    logic [31:0] hist_next [8];

    aes_state_t state_reg, state_next;
    logic [WW-1:0] idx_reg, idx_next;
    logic [3:0]  mod_reg, mod_next;      // i mod nk
    logic [3:0]  rc_reg, rc_next;        // i / nk - 1
    logic [3:0]  round_reg, round_next;
    logic [127:0] cs_reg, cs_next;
    logic         cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index <= REG_KEY_W3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg <= KEY_128;
            for (int k = 0; k < 4; k++) begin
                key_word_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == REG_KEY_SIZE) begin
                key_size_reg <= cfg_data[1:0];
            end else if (cfg_index <= REG_KEY_W3) begin
                key_word_reg[2'(cfg_index - REG_KEY_W0)] <= cfg_data;
            end
        end
    end

    // Expansion word computation.
    logic [31:0] exp_word;
    logic [31:0] t_w;
    logic [31:0] k_init;
    logic        in_init;

    always_comb begin
        in_init = (idx_reg < WW'(nk));
        k_init  = idx_reg[0] ? key_word_reg[2'(idx_reg >> 1)][31:0]
                             : key_word_reg[2'(idx_reg >> 1)][63:32];
        t_w = hist_reg[0];
        if (mod_reg == 4'd0) begin
            t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ {rcon(rc_reg), 24'h0};
        end else if (nk > 4'd6 && mod_reg == 4'd4) begin
            t_w = sub_word(t_w);
        end
        exp_word = in_init ? k_init : (hist_reg[3'(nk - 4'd1)] ^ t_w);
    end

    // Round-key store, organised as one 128-bit round key per entry so that
    // the shared round unit gets a whole key every cycle. Each expanded word
    // is written into its column of the entry for its round.
    logic [127:0] rkey_reg [15];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXPAND && idx_reg < total_words) begin
            rkey_reg[4'(idx_reg >> 2)][127 - 32*idx_reg[1:0] -: 32] <= exp_word;
        end
    end

    // Shift line of previous words.
    always_comb begin
        hist_next[0] = exp_word;
        for (int k = 1; k < 8; k++) begin
            hist_next[k] = hist_reg[k-1];
        end
    end

    logic [127:0] round_out;
    logic [127:0] plain;

    assign plain = {s_data.plain_high, s_data.plain_low};

    aes_round u_round (
        .state_in  (cs_reg),
        .round_key (rkey_reg[round_reg]),
        .do_mix    (round_reg != num_rounds),
        .state_out (round_out)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_EXPAND: if (idx_reg + WW'(1) >= total_words) state_next = ST_IDLE;
            ST_IDLE:   if (cfg_hit) state_next = ST_EXPAND;
                       else if (s_valid && s_ready) state_next = ST_ROUND;
            ST_ROUND:  if (round_reg == num_rounds) state_next = ST_DONE;
            ST_DONE:   if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        if (cfg_hit) begin
            state_next = ST_EXPAND;
        end
    end

    // Datapath and counter updates.
    always_comb begin
        idx_next    = idx_reg;
        mod_next    = mod_reg;
        rc_next     = rc_reg;
        round_next  = round_reg;
        cs_next     = cs_reg;
        case (state_reg)
            ST_EXPAND: begin
                idx_next = idx_reg + WW'(1);
                if (mod_reg + 4'd1 == nk) begin
                    mod_next = 4'd0;
                    rc_next  = in_init ? 4'd0 : rc_reg + 4'd1;
                end else begin
                    mod_next = mod_reg + 4'd1;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cs_next    = plain ^ rkey_reg[0];
                    round_next = 4'd1;
                end
            end
            ST_ROUND: begin
                cs_next    = round_out;
                round_next = round_reg + 4'd1;
            end
            default: ;
        endcase
        if (cfg_hit) begin
            idx_next = '0;
            mod_next = 4'd0;
            rc_next  = 4'd0;
        end
    end

    // Output logic.
    always_comb begin
        s_ready = (state_reg == ST_IDLE) && !cfg_we;
        m_valid = (state_reg == ST_DONE);
        m_data  = {cs_reg[127:64], cs_reg[63:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_EXPAND;
            idx_reg    <= '0;
            mod_reg    <= 4'd0;
            rc_reg     <= 4'd0;
            round_reg  <= 4'd0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            mod_reg    <= mod_next;
            rc_reg     <= rc_next;
            round_reg  <= round_next;
        end
        cs_reg     <= cs_next;
        if (state_reg == ST_EXPAND) begin
            for (int k = 0; k < 8; k++) begin
                hist_reg[k] <= hist_next[k];
            end
        end
    end

endmodule
